>>> rtl/core/chr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chr_pkg
// constants shared by the hash ring lookup unit
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned MaxNodesDefault   = 16;

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001b3;
  localparam logic [63:0] MixC1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixC2    = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] ReqLookup = 2'd0;
  localparam logic [1:0] ReqAdd    = 2'd1;
  localparam logic [1:0] ReqRemove = 2'd2;
  localparam logic [1:0] ReqNone   = 2'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  localparam logic [4:0] VnodesReset = 5'd4;

  localparam logic [7:0] CharHash = 8'h23;
  localparam logic [7:0] CharZero = 8'h30;

endpackage
`default_nettype wire

>>> rtl/core/consistent_hash_ring_lookup_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_unit
// sorted ring of virtual node points with byte-serial hashing and lookup walk
// ----------------------------------------------------------------------------
// Requests are string bytes: start with req_type_i, data_byte_i, last_i,
// node_id_i and want_count_i, taken at an edge with start high and busy low.
// Each byte keeps busy high through three partial products on one shared
// 32x32 multiplier, which make up the 64-bit FNV-1a product, then through an
// update state; a byte without last can be followed by the next once idle.
// On the last byte the request runs on: each finaliser multiply takes three
// more partial products, each binary search step three states (one table
// read), and a lookup walks the ring at three states a point until want_count
// ids are found or every point is seen. An add or remove hashes each virtual
// suffix (a multiply a character, then the finaliser), searches, and shifts
// the table at three states an entry; cost grows with fill and virtual_nodes.
// Each result is held until the next one is found or the request ends, then
// shows for one cycle on result_valid_o; the receiver cannot stall.
// The configuration channel cfg_valid_i/cfg_ready_o writes virtual_nodes; it
// is ready whenever the unit is idle. Reset empties the ring, restores the
// running hash basis and sets virtual_nodes to 4. No clearing pass is needed.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup_unit #(
  parameter int unsigned TableDepth = chr_pkg::TableDepthDefault,
  parameter int unsigned MaxNodes   = chr_pkg::MaxNodesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output      logic       busy,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  input  wire logic [3:0] node_id_i,
  input  wire logic [4:0] want_count_i,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [4:0] cfg_data_i,
  output      logic       result_valid_o,
  output      logic [3:0] result_node_o,
  output      logic       found_o,
  output      logic [1:0] status_o,
  output      logic       end_of_run_o
);
  import chr_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = AW + 1;

  // state codes
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL    = 5'd1;  // partial product cycles
  localparam logic [4:0] S_BYTE   = 5'd2;  // byte done, dispatch
  localparam logic [4:0] S_MIX    = 5'd3;  // finaliser steps
  localparam logic [4:0] S_SRCH   = 5'd4;
  localparam logic [4:0] S_SRDW   = 5'd5;  // wait read data
  localparam logic [4:0] S_SRCMP  = 5'd6;
  localparam logic [4:0] S_WALKRD = 5'd7;
  localparam logic [4:0] S_WALKW  = 5'd8;
  localparam logic [4:0] S_WALK   = 5'd9;
  localparam logic [4:0] S_VSTART = 5'd10;
  localparam logic [4:0] S_VDIG   = 5'd11;
  localparam logic [4:0] S_HITRD  = 5'd12;
  localparam logic [4:0] S_HITW   = 5'd13;
  localparam logic [4:0] S_HIT    = 5'd14;
  localparam logic [4:0] S_SHRD   = 5'd15;
  localparam logic [4:0] S_SHW    = 5'd16;
  localparam logic [4:0] S_SHWR   = 5'd17;
  localparam logic [4:0] S_VNEXT  = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  // what to do after a multiply finishes
  localparam logic [2:0] M_BYTE = 3'd0;
  localparam logic [2:0] M_MIX1 = 3'd1;
  localparam logic [2:0] M_MIX2 = 3'd2;
  localparam logic [2:0] M_VDIG = 3'd3;

  logic [4:0]  state_q, state_d;
  logic [63:0] run_q, run_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] ma_q, ma_d;
  logic [63:0] mb_q, mb_d;
  logic [1:0]  mstep_q, mstep_d;
  logic [2:0]  mnext_q, mnext_d;
  logic [1:0]  type_q, type_d;
  logic [3:0]  node_q, node_d;
  logic [4:0]  want_q, want_d;
  logic [4:0]  vnodes_q, vnodes_d;
  logic [CW-1:0] count_q, count_d;
  logic [63:0] key_q, key_d;
  logic [63:0] pre_q, pre_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0] pos_q, pos_d, vis_q, vis_d;
  logic [4:0]  k_q, k_d;
  logic [15:0] seen_q, seen_d;
  logic [4:0]  vi_q, vi_d;
  logic [1:0]  dig_q, dig_d;
  logic [1:0]  ndig_q, ndig_d;
  logic        full_q, full_d;
  logic [CW-1:0] j_q, j_d;
  logic        rv_d;
  logic [3:0]  rn_q, rn_d;
  logic        rf_q, rf_d;
  logic [1:0]  rs_q, rs_d;
  logic        re_q, re_d;

  // table memory
  logic [63:0] mem_h [TableDepth];
  logic [3:0]  mem_n [TableDepth];
  logic [AW-1:0] raddr;
  logic [63:0] rd_h;
  logic [3:0]  rd_n;
  logic        we;
  logic [AW-1:0] waddr;
  logic [63:0] wd_h;
  logic [3:0]  wd_n;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_h[waddr] <= wd_h;
      mem_n[waddr] <= wd_n;
    end
    rd_h <= mem_h[raddr];
    rd_n <= mem_n[raddr];
  end

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (mstep_q)
      2'd0:    begin mul_a = ma_q[31:0];  mul_b = mb_q[31:0];  end
      2'd1:    begin mul_a = ma_q[63:32]; mul_b = mb_q[31:0];  end
      2'd2:    begin mul_a = ma_q[31:0];  mul_b = mb_q[63:32]; end
      default: begin mul_a = 32'd0;       mul_b = 32'd0;       end
    endcase
  end

  // decimal digit of the virtual index, most significant first
  logic [7:0] dig_char;
  always_comb begin
    if (ndig_q == 2'd2 && dig_q == 2'd0) begin
      dig_char = CharZero + ((vi_q >= 5'd30) ? 8'd3 : (vi_q >= 5'd20) ? 8'd2 : 8'd1);
    end else begin
      dig_char = CharZero + ((vi_q >= 5'd30) ? {3'd0, vi_q - 5'd30} :
                             (vi_q >= 5'd20) ? {3'd0, vi_q - 5'd20} :
                             (vi_q >= 5'd10) ? {3'd0, vi_q - 5'd10} : {3'd0, vi_q});
    end
  end

  logic [CW-1:0] mid;
  logic [4:0]    want_sat;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign want_sat = (want_count_i > 5'd16) ? 5'd16 :
                    ({27'd0, want_count_i} > MaxNodes) ? 5'(MaxNodes) : want_count_i;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q; run_d = run_q; acc_d = acc_q; ma_d = ma_q; mb_d = mb_q;
    mstep_d = mstep_q; mnext_d = mnext_q; type_d = type_q; node_d = node_q;
    want_d = want_q; vnodes_d = vnodes_q; count_d = count_q; key_d = key_q;
    pre_d = pre_q; lo_d = lo_q; hi_d = hi_q; pos_d = pos_q; vis_d = vis_q;
    k_d = k_q; seen_d = seen_q; vi_d = vi_q; dig_d = dig_q; ndig_d = ndig_q;
    full_d = full_q; j_d = j_q;
    rv_d = 1'b0; rn_d = rn_q; rf_d = rf_q; rs_d = rs_q; re_d = re_q;
    raddr = mid[AW-1:0]; we = 1'b0; waddr = pos_q[AW-1:0];
    wd_h = key_q; wd_n = node_q;

    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) vnodes_d = cfg_data_i;
        if (start && req_type_i != ReqNone) begin
          type_d = req_type_i; node_d = node_id_i; want_d = want_sat;
          ma_d = run_q ^ {56'd0, data_byte_i}; mb_d = FnvPrime;
          acc_d = 64'd0; mstep_d = 2'd0; mnext_d = M_BYTE;
          type_d = last_i ? req_type_i : ReqNone;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        case (mstep_q)
          2'd0:    acc_d = mul_p;
          default: acc_d = acc_q + {mul_p[31:0], 32'd0};
        endcase
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd2) begin
          mstep_d = 2'd0;
          case (mnext_q)
            M_BYTE: state_d = S_BYTE;
            M_MIX1: state_d = S_MIX;
            M_MIX2: state_d = S_MIX;
            M_VDIG: state_d = S_VDIG;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_BYTE: begin
        if (type_q == ReqNone) begin
          run_d = acc_q; state_d = S_IDLE;
        end else begin
          run_d = FnvBasis;
          if (type_q == ReqLookup) begin
            if (count_q == '0) begin
              rv_d = 1'b1; rn_d = 4'd0; rf_d = 1'b0; rs_d = StatusEmpty; re_d = 1'b1;
              state_d = S_DONE;
            end else if (want_q == 5'd0) begin
              // nothing asked for on a filled ring
              state_d = S_IDLE;
            end else begin
              ma_d = acc_q ^ (acc_q >> 33); mb_d = MixC1; mnext_d = M_MIX1;
              state_d = S_MUL;
            end
          end else begin
            pre_d = acc_q; vi_d = 5'd0; full_d = 1'b0;
            state_d = S_VSTART;
          end
        end
      end
      S_MIX: begin
        if (mnext_q == M_MIX1) begin
          ma_d = acc_q ^ (acc_q >> 33); mb_d = MixC2; mnext_d = M_MIX2;
          state_d = S_MUL;
        end else begin
          key_d = acc_q ^ (acc_q >> 33);
          lo_d = '0; hi_d = count_q; state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) state_d = S_SRDW;
        else begin
          pos_d = lo_q;
          if (type_q == ReqLookup) begin
            vis_d = '0; k_d = 5'd0; seen_d = 16'd0;
            if (lo_q >= count_q) pos_d = '0;
            state_d = S_WALKRD;
          end else begin
            state_d = S_HITRD;
          end
        end
      end
      S_SRDW: state_d = S_SRCMP;
      S_SRCMP: begin
        if (rd_h < key_q) lo_d = mid + 1'b1;
        else hi_d = mid;
        state_d = S_SRCH;
      end
      S_WALKRD: begin
        raddr = pos_q[AW-1:0]; state_d = S_WALKW;
      end
      S_WALKW: begin
        raddr = pos_q[AW-1:0]; state_d = S_WALK;
      end
      S_WALK: begin
        vis_d = vis_q + 1'b1;
        pos_d = (pos_q + 1'b1 >= count_q) ? '0 : pos_q + 1'b1;
        if (!seen_q[rd_n]) begin
          seen_d[rd_n] = 1'b1;
          k_d = k_q + 5'd1;
          rv_d = 1'b1; rn_d = rd_n; rf_d = 1'b1; rs_d = StatusOk;
          re_d = (k_q + 5'd1 == want_q) || (vis_q + 1'b1 == count_q);
        end else if (vis_q + 1'b1 == count_q) begin
          // final visit produced nothing: mark the previous result as last
          re_d = 1'b1;
        end
        if ((!seen_q[rd_n] && k_q + 5'd1 == want_q) || vis_q + 1'b1 == count_q)
          state_d = S_IDLE;
        else state_d = S_WALKRD;
      end
      S_VSTART: begin
        if (vi_q >= vnodes_q) begin
          rv_d = 1'b1; rn_d = 4'd0; rf_d = 1'b0;
          rs_d = full_q ? StatusFull : StatusOk; re_d = 1'b1;
          state_d = S_DONE;
        end else begin
          ma_d = pre_q ^ {56'd0, CharHash}; mb_d = FnvPrime;
          ndig_d = (vi_q >= 5'd10) ? 2'd2 : 2'd1; dig_d = 2'd0;
          mnext_d = M_VDIG; state_d = S_MUL;
        end
      end
      S_VDIG: begin
        if (dig_q == ndig_q) begin
          ma_d = acc_q ^ (acc_q >> 33); mb_d = MixC1; mnext_d = M_MIX1;
          state_d = S_MUL;
        end else begin
          ma_d = acc_q ^ {56'd0, dig_char}; mb_d = FnvPrime;
          dig_d = dig_q + 2'd1; state_d = S_MUL;
        end
      end
      S_HITRD: begin
        raddr = pos_q[AW-1:0]; state_d = S_HITW;
      end
      S_HITW: begin
        raddr = pos_q[AW-1:0]; state_d = S_HIT;
      end
      S_HIT: begin
        if (pos_q < count_q && rd_h == key_q) begin
          if (type_q == ReqAdd) begin
            we = 1'b1; state_d = S_VNEXT;
          end else begin
            j_d = pos_q; state_d = S_SHRD;
          end
        end else if (type_q == ReqAdd) begin
          if ({1'b0, count_q} < (CW+1)'(TableDepth)) begin
            j_d = count_q; state_d = S_SHRD;
          end else begin
            full_d = 1'b1; state_d = S_VNEXT;
          end
        end else state_d = S_VNEXT;
      end
      S_SHRD: begin
        // insert shifts entries up from the top, remove shifts down
        if (type_q == ReqAdd) begin
          if (j_q == pos_q) begin
            we = 1'b1; count_d = count_q + 1'b1; state_d = S_VNEXT;
          end else begin
            raddr = AW'(j_q - 1'b1); state_d = S_SHW;
          end
        end else begin
          if (j_q + 1'b1 >= count_q) begin
            count_d = count_q - 1'b1; state_d = S_VNEXT;
          end else begin
            raddr = AW'(j_q + 1'b1); state_d = S_SHW;
          end
        end
      end
      S_SHW: begin
        raddr = (type_q == ReqAdd) ? AW'(j_q - 1'b1) : AW'(j_q + 1'b1);
        state_d = S_SHWR;
      end
      S_SHWR: begin
        we = 1'b1; waddr = j_q[AW-1:0]; wd_h = rd_h; wd_n = rd_n;
        j_d = (type_q == ReqAdd) ? j_q - 1'b1 : j_q + 1'b1;
        state_d = S_SHRD;
      end
      S_VNEXT: begin
        vi_d = vi_q + 5'd1; state_d = S_VSTART;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    // multiply result leads to search for add/remove finaliser
    if (state_q == S_MIX && mnext_q == M_MIX2 && type_q != ReqLookup) begin
      key_d = acc_q ^ (acc_q >> 33);
    end
  end

  // delayed end marking: a result is held back so a trailing end mark can join it
  logic       hold_v_q;
  logic [3:0] hold_n_q;
  logic       hold_f_q;
  logic [1:0] hold_s_q;
  logic       hold_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; run_q <= FnvBasis; count_q <= '0; vnodes_q <= VnodesReset;
      mstep_q <= 2'd0; hold_v_q <= 1'b0;
    end else begin
      state_q <= state_d; run_q <= run_d; count_q <= count_d; vnodes_q <= vnodes_d;
      mstep_q <= mstep_d;
      if (rv_d) hold_v_q <= 1'b1;
      else if (hold_v_q && (re_d || state_d == S_IDLE || state_q == S_IDLE)) hold_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; ma_q <= ma_d; mb_q <= mb_d; mnext_q <= mnext_d;
    type_q <= type_d; node_q <= node_d; want_q <= want_d; key_q <= key_d;
    pre_q <= pre_d; lo_q <= lo_d; hi_q <= hi_d; pos_q <= pos_d; vis_q <= vis_d;
    k_q <= k_d; seen_q <= seen_d; vi_q <= vi_d; dig_q <= dig_d; ndig_q <= ndig_d;
    full_q <= full_d; j_q <= j_d;
    rn_q <= rn_d; rf_q <= rf_d; rs_q <= rs_d; re_q <= re_d;
    if (rv_d) begin
      hold_n_q <= rn_d; hold_f_q <= rf_d; hold_s_q <= rs_d; hold_e_q <= re_d;
    end else if (re_d) begin
      hold_e_q <= 1'b1;
    end
  end

  // a held result leaves when the next one arrives or the request finishes
  logic flush;
  assign flush = hold_v_q && (rv_d || re_d || state_d == S_IDLE);
  assign result_valid_o = flush;
  assign result_node_o  = hold_n_q;
  assign found_o        = hold_f_q;
  assign status_o       = hold_s_q;
  assign end_of_run_o   = hold_e_q || (re_d && !rv_d) || (state_d == S_IDLE && !rv_d);

  property p_cfg_idle;
    @(posedge clk_i) disable iff (!rst_ni) cfg_ready_o |-> !busy;
  endproperty
  a_cfg_idle: assert property (p_cfg_idle) else $error("cfg ready while busy");

  property p_count_range;
    @(posedge clk_i) disable iff (!rst_ni) {1'b0, count_q} <= (CW+1)'(TableDepth);
  endproperty
  a_count_range: assert property (p_count_range) else $error("point count overflow");

  property p_mstep;
    @(posedge clk_i) disable iff (!rst_ni) mstep_q != 2'd3;
  endproperty
  a_mstep: assert property (p_mstep) else $error("bad multiply step");

endmodule
`default_nettype wire

>>> tb/consistent_hash_ring_lookup_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_unit_test
// self-checking bench for the hash ring lookup unit
// ----------------------------------------------------------------------------
// Feeds key and address strings one byte per request. A directed table comes
// first, then random strings under several virtual node counts. Every
// accepted byte goes through a local model of the ring, and each result
// strobe is checked against the oldest expected result.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup_unit_test;
  import chr_pkg::*;

  localparam int unsigned Depth      = 256;
  localparam int unsigned IdCap      = 16;
  localparam int unsigned SettleCyc  = 800;
  localparam longint      CycleLimit = 2000000;

  typedef struct packed {
    logic [3:0] node;
    logic       found;
    logic [1:0] status;
    logic       eor;
  } ring_res_t;

  typedef struct packed {
    logic [1:0] rtype;
    logic [7:0] data;
    logic       last;
    logic [3:0] node;
    logic [4:0] want;
    logic       known;
    ring_res_t  res;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
  } addr_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] req_type_i = ReqLookup;
  logic [7:0] data_byte_i = '0;
  logic       last_i = 1'b0;
  logic [3:0] node_id_i = '0;
  logic [4:0] want_count_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i = '0;
  logic       result_valid_o;
  logic [3:0] result_node_o;
  logic       found_o;
  logic [1:0] status_o;
  logic       end_of_run_o;

  consistent_hash_ring_lookup_unit uut (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .data_byte_i, .last_i,
    .node_id_i, .want_count_i, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .result_valid_o, .result_node_o, .found_o, .status_o, .end_of_run_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ring model
  logic [63:0] ring_hash [Depth];
  logic [3:0]  ring_node [Depth];
  int unsigned ring_fill;
  logic [63:0] byte_hash;
  logic [4:0]  vnode_cnt;
  ring_res_t   step_res[$];
  ring_res_t   pending_res[$];

  function automatic logic [63:0] fold_byte(logic [63:0] h, logic [7:0] b);
    return (h ^ {56'd0, b}) * FnvPrime;
  endfunction

  function automatic logic [63:0] finalise(logic [63:0] h);
    h = h ^ (h >> 33);
    h = h * MixC1;
    h = h ^ (h >> 33);
    h = h * MixC2;
    h = h ^ (h >> 33);
    return h;
  endfunction

  function automatic int unsigned first_at_or_above(logic [63:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = ring_fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (ring_hash[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [63:0] point_of(logic [63:0] prefix, int unsigned idx);
    logic [63:0] h;
    h = fold_byte(prefix, CharHash);
    if (idx >= 10) h = fold_byte(h, CharZero + 8'(idx / 10));
    h = fold_byte(h, CharZero + 8'(idx % 10));
    return finalise(h);
  endfunction

  function automatic void ring_step(logic [1:0] rtype, logic [7:0] data, logic last,
                                    logic [3:0] node, logic [4:0] want);
    logic [63:0] h, ph;
    logic [15:0] seen;
    int unsigned pos, visited, cap, i, j;
    logic [1:0] st;
    ring_res_t r;
    step_res.delete();
    if (rtype == ReqNone) return;
    byte_hash = fold_byte(byte_hash, data);
    if (!last) return;
    h = byte_hash;
    byte_hash = FnvBasis;
    if (rtype == ReqLookup) begin
      if (ring_fill == 0) begin
        r = '{4'd0, 1'b0, StatusEmpty, 1'b1};
        step_res.insert(step_res.size(), r);
        return;
      end
      cap = (want > IdCap) ? IdCap : want;
      seen = '0;
      visited = 0;
      pos = first_at_or_above(finalise(h));
      while (step_res.size() < cap && visited < ring_fill) begin
        if (pos >= ring_fill) pos = 0;
        if (!seen[ring_node[pos]]) begin
          seen[ring_node[pos]] = 1'b1;
          r = '{ring_node[pos], 1'b1, StatusOk, 1'b0};
          step_res.insert(step_res.size(), r);
        end
        pos++;
        visited++;
      end
      if (step_res.size() > 0) begin
        r = step_res.pop_back();
        r.eor = 1'b1;
        step_res.insert(step_res.size(), r);
      end
      return;
    end
    st = StatusOk;
    for (i = 0; i < vnode_cnt; i++) begin
      ph = point_of(h, i);
      pos = first_at_or_above(ph);
      if (pos < ring_fill && ring_hash[pos] == ph) begin
        if (rtype == ReqAdd) ring_node[pos] = node;
        else begin
          for (j = pos; j + 1 < ring_fill; j++) begin
            ring_hash[j] = ring_hash[j + 1];
            ring_node[j] = ring_node[j + 1];
          end
          ring_fill--;
        end
      end else if (rtype == ReqAdd) begin
        if (ring_fill < Depth) begin
          for (j = ring_fill; j > pos; j--) begin
            ring_hash[j] = ring_hash[j - 1];
            ring_node[j] = ring_node[j - 1];
          end
          ring_hash[pos] = ph;
          ring_node[pos] = node;
          ring_fill++;
        end else st = StatusFull;
      end
    end
    r = '{4'd0, 1'b0, st, 1'b1};
    step_res.insert(step_res.size(), r);
  endfunction

  // typed expectation for the directed request currently on the bus
  logic      row_known = 1'b0;
  ring_res_t row_res = '0;

  int     errors = 0;
  int     n_req = 0;
  int     n_res = 0;
  int     n_full = 0;
  int     n_empty = 0;
  longint cycles = 0;

  always @(posedge clk_i) begin
    ring_res_t got, want_r;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_res.size());
      $display("simulation failed");
      $finish;
    end
    if (rst_ni) begin
      if (result_valid_o) begin
        got = '{result_node_o, found_o, status_o, end_of_run_o};
        n_res++;
        if (status_o == StatusFull) n_full++;
        if (status_o == StatusEmpty) n_empty++;
        if (pending_res.size() == 0) begin
          $display("%0t unexpected result %p", $time, got);
          errors++;
        end else begin
          want_r = pending_res.pop_front();
          if (got !== want_r) begin
            $display("%0t mismatch: expected %p, got %p", $time, want_r, got);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) vnode_cnt = cfg_data_i;
      if (start && !busy) begin
        n_req++;
        ring_step(req_type_i, data_byte_i, last_i, node_id_i, want_count_i);
        if (row_known) pending_res.insert(pending_res.size(), row_res);
        else foreach (step_res[k]) pending_res.insert(pending_res.size(), step_res[k]);
      end
    end
  end

  int unsigned idle_pct = 0;

  task automatic send_req(logic [1:0] rtype, logic [7:0] data, logic last,
                          logic [3:0] node, logic [4:0] want);
    req_type_i = rtype;
    data_byte_i = data;
    last_i = last;
    node_id_i = node;
    want_count_i = want;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    start = 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    // adds and lookups with no result may still be running
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_vnodes(logic [4:0] v);
    drain_and_settle();
    cfg_data_i = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  addr_t known_addr[$];

  task automatic send_string(logic [1:0] rtype, addr_t a, logic [3:0] node,
                             logic [4:0] want, bit noisy);
    logic [1:0] t;
    for (int i = 0; i < a.len; i++) begin
      if (noisy && $urandom_range(3) == 0)
        send_req(ReqNone, 8'($urandom), 1'b0, 4'($urandom), 5'($urandom));
      t = (noisy && $urandom_range(2) == 0) ? 2'($urandom_range(0, 2)) : rtype;
      if (i == a.len - 1) t = rtype;
      send_req(t, a.bytes[8*i +: 8], i == a.len - 1, node, want);
    end
  endtask

  task automatic random_phase(int unsigned n_str, int unsigned add_w, int unsigned pct,
                              bit pause_mid);
    addr_t a;
    logic [1:0] rt;
    int unsigned pick;
    logic [4:0] w;
    idle_pct = pct;
    for (int s = 0; s < n_str; s++) begin
      if (pause_mid && s == n_str / 2) begin
        start = 1'b0;
        while (pending_res.size() != 0) @(negedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < add_w) rt = ReqAdd;
      else if (pick < add_w + (100 - add_w) / 3) rt = ReqRemove;
      else rt = ReqLookup;
      a.bytes = $urandom;
      a.len = 3'($urandom_range(1, 3));
      if (rt == ReqRemove && known_addr.size() > 0 && $urandom_range(3) != 0)
        a = known_addr[$urandom_range(known_addr.size() - 1)];
      if (rt == ReqAdd) known_addr.insert(known_addr.size(), a);
      w = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
      send_string(rt, a, 4'($urandom), w, $urandom_range(9) == 0);
    end
  endtask

  dir_row_t dir_rows [17] = '{
    '{ReqLookup, 8'h6b, 1'b1, 4'd0,  5'd1,  1'b1, '{4'd0, 1'b0, StatusEmpty, 1'b1}},
    '{ReqNone,   8'h78, 1'b1, 4'd3,  5'd2,  1'b0, '0},
    '{ReqAdd,    8'h41, 1'b1, 4'd0,  5'd1,  1'b1, '{4'd0, 1'b0, StatusOk, 1'b1}},
    '{ReqAdd,    8'hff, 1'b1, 4'd15, 5'd1,  1'b1, '{4'd0, 1'b0, StatusOk, 1'b1}},
    '{ReqLookup, 8'h00, 1'b0, 4'd0,  5'd0,  1'b0, '0},
    '{ReqLookup, 8'hff, 1'b1, 4'd0,  5'd31, 1'b0, '0},
    '{ReqLookup, 8'h71, 1'b1, 4'd0,  5'd0,  1'b0, '0},
    '{ReqLookup, 8'h7a, 1'b1, 4'd0,  5'd1,  1'b0, '0},
    '{ReqLookup, 8'h7a, 1'b1, 4'd0,  5'd16, 1'b0, '0},
    '{ReqLookup, 8'h42, 1'b0, 4'd2,  5'd3,  1'b0, '0},
    '{ReqAdd,    8'h37, 1'b1, 4'd7,  5'd3,  1'b1, '{4'd0, 1'b0, StatusOk, 1'b1}},
    '{ReqRemove, 8'hff, 1'b1, 4'd0,  5'd0,  1'b1, '{4'd0, 1'b0, StatusOk, 1'b1}},
    '{ReqRemove, 8'h51, 1'b1, 4'd0,  5'd0,  1'b1, '{4'd0, 1'b0, StatusOk, 1'b1}},
    '{ReqLookup, 8'h80, 1'b1, 4'd0,  5'd5,  1'b0, '0},
    '{ReqAdd,    8'h55, 1'b1, 4'd10, 5'd1,  1'b1, '{4'd0, 1'b0, StatusOk, 1'b1}},
    '{ReqAdd,    8'h55, 1'b1, 4'd5,  5'd1,  1'b1, '{4'd0, 1'b0, StatusOk, 1'b1}},
    '{ReqLookup, 8'haa, 1'b1, 4'd0,  5'd16, 1'b0, '0}
  };

  initial begin
    ring_fill = 0;
    byte_hash = FnvBasis;
    vnode_cnt = VnodesReset;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_pct = 6;
    foreach (dir_rows[i]) begin
      row_known = dir_rows[i].known;
      row_res = dir_rows[i].res;
      send_req(dir_rows[i].rtype, dir_rows[i].data, dir_rows[i].last,
               dir_rows[i].node, dir_rows[i].want);
    end
    row_known = 1'b0;

    random_phase(20, 35, 6, 1'b1);
    write_vnodes(5'd1);
    random_phase(15, 35, 45, 1'b0);
    write_vnodes(5'd16);
    random_phase(15, 35, 45, 1'b0);
    write_vnodes(5'd0);
    random_phase(6, 50, 0, 1'b0);
    // wide fan-out fills the table so later adds get dropped
    write_vnodes(5'd31);
    random_phase(20, 60, 0, 1'b0);
    write_vnodes(5'd7);
    random_phase(8, 30, 0, 1'b0);

    drain_and_settle();
    $display("%0d requests accepted, %0d results checked (%0d table full, %0d ring empty)",
             n_req, n_res, n_full, n_empty);
    $display("virtual node counts 4, 1, 16, 0, 31 and 7 exercised, %0d errors", errors);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
